/* rtl/pol_pkg.sv */
// ----------------------------------------------------------------------------
// pol_pkg: shared definitions for the positional ordered list
// Sizes, request and status codes, and the command word sent to the cells.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int LEN_W  = 5;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_READ       = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Broadcast to every cell in the cycle a transaction is accepted.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } shift_cmd_t;

endpackage

/* rtl/pol_cell.sv */
// ----------------------------------------------------------------------------
// pol_cell: one storage cell of the list
// Holds one entry and either keeps it, loads the new value, takes the entry
// of the lower neighbor (insert) or of the upper neighbor (remove).
// ----------------------------------------------------------------------------
module pol_cell
  import pol_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_idx,
  input  shift_cmd_t        cmd,
  input  logic [DATA_W-1:0] lower_q,
  input  logic [DATA_W-1:0] upper_q,
  output logic [DATA_W-1:0] entry_q
);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (cell_idx == cmd.pos) begin
        entry_nxt = cmd.value;
      end else if (cell_idx > cmd.pos) begin
        entry_nxt = lower_q;
      end
    end else if (cmd.rem) begin
      if (cell_idx >= cmd.pos) begin
        entry_nxt = upper_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

/* rtl/positional_ordered_list.sv */
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list with positional access
// A row of cells holds the entries; insert and remove shift all cells at or
// above the position at once, so each request finishes in the cycle it is accepted.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_ready | req_type, item_value, position
//  out_    | output    | out_valid/out_ready | read_value, status, length
//
// For every request, status, shift and length are decided in the
// acceptance cycle and the result lands in the output register.
// A new transaction is taken each cycle while the output register is empty
// or being drained, so throughput is one request per cycle.
// A stalled result holds in_ready low; nothing else stalls the block.
// Reset clears the length and the output valid; entry contents are not reset.
// ----------------------------------------------------------------------------
module positional_ordered_list
  import pol_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_req_type,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [1:0]               out_status,
  output logic [LEN_W-1:0]         out_length
);

  logic              in_accept;
  op_t               op;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CMP_W-1:0]  count_ext;
  logic [CMP_W-1:0]  eff_pos;
  logic              is_ins;
  logic              is_rem;
  status_t           st;
  logic [DATA_W-1:0] rd_data;
  shift_cmd_t        cmd;
  logic [DATA_W-1:0] cell_q [DEPTH];

  logic              out_valid_r;
  logic [DATA_W-1:0] out_read_value_r;
  status_t           out_status_r;
  logic [LEN_W-1:0]  out_length_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign op        = op_t'(in_req_type);
  assign count_ext = CMP_W'(count_r);

  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    eff_pos = CMP_W'(in_position);
    case (op)
      OP_PUSH_FRONT: begin
        is_ins  = 1'b1;
        eff_pos = '0;
      end
      OP_POP_FRONT: begin
        is_rem  = 1'b1;
        eff_pos = '0;
      end
      OP_PUSH_BACK: begin
        is_ins  = 1'b1;
        eff_pos = count_ext;
      end
      OP_POP_BACK: begin
        is_rem  = 1'b1;
        eff_pos = count_ext - CMP_W'(1);
      end
      OP_INSERT: is_ins = 1'b1;
      OP_REMOVE: is_rem = 1'b1;
      default: ;
    endcase
  end

  // Insert tests the range before fullness; remove tests emptiness first.
  always_comb begin
    st        = ST_OK;
    count_nxt = count_r;
    if (is_ins) begin
      if (eff_pos > count_ext) begin
        st = ST_RANGE;
      end else if (count_ext == CMP_W'(DEPTH)) begin
        st = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (is_rem) begin
      if (count_r == '0) begin
        st = ST_EMPTY;
      end else if (eff_pos >= count_ext) begin
        st = ST_RANGE;
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (op == OP_READ) begin
      if (eff_pos >= count_ext) begin
        st = ST_RANGE;
      end
    end else begin
      count_nxt = '0;
    end
  end

  assign cmd.ins   = in_accept && is_ins && (st == ST_OK);
  assign cmd.rem   = in_accept && is_rem && (st == ST_OK);
  assign cmd.pos   = eff_pos[IDX_W-1:0];
  assign cmd.value = in_item_value;

  always_comb begin
    rd_data = '0;
    if ((st == ST_OK) && (is_rem || (op == OP_READ))) begin
      rd_data = cell_q[eff_pos[IDX_W-1:0]];
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] lower_q;
      logic [DATA_W-1:0] upper_q;
      if (gi == 0) begin : g_first
        assign lower_q = '0;
      end else begin : g_lower
        assign lower_q = cell_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign upper_q = cell_q[gi];
      end else begin : g_upper
        assign upper_q = cell_q[gi+1];
      end
      pol_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(gi)),
        .cmd      (cmd),
        .lower_q  (lower_q),
        .upper_q  (upper_q),
        .entry_q  (cell_q[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_read_value_r <= rd_data;
      out_status_r     <= st;
      out_length_r     <= LEN_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_length     = out_length_r;

  a_reset_clears_valid: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_ext <= CMP_W'(DEPTH))
    else $error("list length exceeds depth");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (op == OP_CLEAR) |=> (out_length == '0) && (out_status == ST_OK))
    else $error("clear did not empty the list");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("successful insert did not grow the list");

  a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_read_value == '0)
    else $error("failed transaction returned a nonzero value");

endmodule

/* verif/tb_positional_ordered_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_ordered_list: self-checking bench for the positional list
// Drives push, pop, insert, remove, read and clear requests with random idle
// gaps on both channels. A shadow copy of the list predicts each response,
// and every response is compared in order against it.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list
  import pol_pkg::*;
();

  typedef struct {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic [LEN_W-1:0]         length;
  } list_response_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [2:0]               in_req_type;
  logic signed [DATA_W-1:0] in_item_value;
  logic [POS_W-1:0]         in_position;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_read_value;
  logic [1:0]               out_status;
  logic [LEN_W-1:0]         out_length;

  // Shadow copy of the list contents and its length.
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_len;

  list_response_t pending_responses [$];
  int             error_count;
  bit             sender_idles;
  bit             receiver_idles;
  int             hold_request;

  positional_ordered_list dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_item_value  (in_item_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length     (out_length)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic status_t shadow_insert(int at, logic signed [DATA_W-1:0] value);
    if (at > shadow_len) return ST_RANGE;
    if (shadow_len >= DEPTH) return ST_FULL;
    for (int i = shadow_len; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[at] = value;
    shadow_len++;
    return ST_OK;
  endfunction

  function automatic status_t shadow_remove(int at, output logic signed [DATA_W-1:0] value);
    value = '0;
    if (shadow_len == 0) return ST_EMPTY;
    if (at >= shadow_len) return ST_RANGE;
    value = shadow_entries[at];
    for (int i = at; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
    shadow_len--;
    return ST_OK;
  endfunction

  // Applies one request to the shadow list and returns the response it must give.
  function automatic list_response_t apply_list_request(op_t op,
                                                        logic signed [DATA_W-1:0] value,
                                                        logic [POS_W-1:0] pos);
    list_response_t resp;
    resp.value  = '0;
    resp.status = ST_OK;
    case (op)
      OP_PUSH_FRONT: resp.status = shadow_insert(0, value);
      OP_POP_FRONT:  resp.status = shadow_remove(0, resp.value);
      OP_PUSH_BACK:  resp.status = shadow_insert(shadow_len, value);
      OP_POP_BACK: begin
        if (shadow_len == 0) resp.status = ST_EMPTY;
        else resp.status = shadow_remove(shadow_len - 1, resp.value);
      end
      OP_INSERT:     resp.status = shadow_insert(int'(pos), value);
      OP_REMOVE:     resp.status = shadow_remove(int'(pos), resp.value);
      OP_READ: begin
        if (int'(pos) >= shadow_len) resp.status = ST_RANGE;
        else resp.value = shadow_entries[pos[IDX_W-1:0]];
      end
      default:       shadow_len = 0;
    endcase
    if (resp.status != ST_OK) resp.value = '0;
    resp.length = shadow_len[LEN_W-1:0];
    return resp;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (error_count < 100)
      $display("ERROR: %0t ns %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Offers one request and returns once it has been accepted.
  task automatic send_request(op_t op, logic signed [DATA_W-1:0] value,
                              logic [POS_W-1:0] pos);
    @(negedge clk);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_req_type   = op;
    in_item_value = value;
    in_position   = pos;
    do @(posedge clk); while (!in_ready);
    pending_responses.push_back(apply_list_request(op, value, pos));
  endtask

  always @(posedge clk) begin
    list_response_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("response with no request outstanding", out_length, 0);
      end else begin
        want = pending_responses.pop_front();
        if (out_read_value !== want.value)
          report_mismatch("read_value", out_read_value, want.value);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_length !== want.length)
          report_mismatch("length", out_length, want.length);
      end
    end
  end

  // Response side: random stalls, plus a long hold when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_ready = 1'b0;
        for (int c = 0; c < hold_request; c++) @(negedge clk);
        hold_request = 0;
        out_ready = 1'b1;
      end else if (receiver_idles && rst_n && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = rst_n;
      end
    end
  end

  task automatic test_empty_and_range_errors();
    send_request(OP_POP_FRONT, 32'sd5, 5'd0);
    send_request(OP_POP_BACK, 32'sd5, 5'd0);
    send_request(OP_REMOVE, 32'sd5, 5'd0);
    send_request(OP_READ, 32'sd0, 5'd0);
    send_request(OP_INSERT, 32'sd9, 5'd1);
  endtask

  task automatic test_each_operation();
    send_request(OP_PUSH_FRONT, 32'sh7fffffff, 5'd0);
    send_request(OP_PUSH_BACK, 32'sh80000000, 5'd31);
    send_request(OP_INSERT, -32'sd1, 5'd1);
    // Inserting at the current length behaves as a push to the back.
    send_request(OP_INSERT, 32'sd0, 5'd3);
    send_request(OP_INSERT, 32'sh5a5a5a5a, 5'd0);
    send_request(OP_READ, 32'sd0, 5'd16);
    send_request(OP_READ, 32'sd0, 5'd2);
    send_request(OP_REMOVE, 32'sd0, 5'd5);
    send_request(OP_REMOVE, 32'sd0, 5'd2);
    send_request(OP_POP_FRONT, 32'sd0, 5'd0);
    send_request(OP_POP_BACK, 32'sd0, 5'd0);
    send_request(OP_CLEAR, -32'sd1, 5'd31);
    send_request(OP_READ, 32'sd0, 5'd0);
  endtask

  task automatic test_full_list();
    for (int i = 0; i < DEPTH; i++) send_request(OP_PUSH_BACK, $urandom(), 5'd0);
    send_request(OP_PUSH_FRONT, 32'sd1, 5'd0);
    send_request(OP_PUSH_BACK, 32'sd1, 5'd0);
    // On a full list the range test wins over the full test.
    send_request(OP_INSERT, 32'sd1, 5'd17);
    send_request(OP_INSERT, 32'sd1, 5'd16);
    send_request(OP_READ, 32'sd0, 5'd15);
    send_request(OP_READ, 32'sd0, 5'd16);
    send_request(OP_CLEAR, 32'sd0, 5'd0);
  endtask

  task automatic test_random_traffic(int n_items);
    bit               grow;
    int               roll;
    int               bound;
    op_t              op;
    logic [POS_W-1:0] pos;
    grow = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (shadow_len == DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      if (shadow_len == 0) grow = 1'b1;
      if ($urandom_range(0, 49) == 0) grow = !grow;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        op = OP_CLEAR;
      end else if (roll < 20) begin
        op = OP_READ;
      end else if (roll < (grow ? 75 : 40)) begin
        case ($urandom_range(0, 2))
          0: op = OP_PUSH_FRONT;
          1: op = OP_PUSH_BACK;
          default: op = OP_INSERT;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: op = OP_POP_FRONT;
          1: op = OP_POP_BACK;
          default: op = OP_REMOVE;
        endcase
      end
      bound = (op == OP_INSERT) ? shadow_len : ((shadow_len > 0) ? shadow_len - 1 : 0);
      if ($urandom_range(0, 6) == 0) pos = POS_W'($urandom_range(0, DEPTH));
      else pos = POS_W'($urandom_range(0, bound));
      send_request(op, $urandom(), pos);
    end
  endtask

  // Holds the response side off long enough that the input backs up.
  task automatic test_backpressure();
    sender_idles = 1'b0;
    hold_request = 60;
    test_random_traffic(40);
    sender_idles = 1'b1;
  endtask

  initial begin
    error_count    = 0;
    hold_request   = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    shadow_len     = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = OP_CLEAR;
    in_item_value  = '0;
    in_position    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_range_errors();
    test_each_operation();
    test_full_list();
    test_random_traffic(1300);
    test_backpressure();
    test_random_traffic(200);
    // Last stretch runs with both sides always ready.
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    test_random_traffic(300);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("PASS positional_ordered_list");
    else $display("FAIL positional_ordered_list");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL positional_ordered_list");
    $finish;
  end

endmodule

/* files.f */
rtl/pol_pkg.sv
rtl/pol_cell.sv
rtl/positional_ordered_list.sv
verif/tb_positional_ordered_list.sv
